### design/dpc_pkg.sv
// shared types, constants and rounding helpers for the disc pair collision unit
package dpc_pkg;

	localparam int RAD_W    = 25;
	localparam int FAC_W    = 17;
	localparam int SQ_W     = 53;
	localparam int DIST_W   = 27;
	localparam int D_W      = 27;
	localparam int N_W      = 19;

	localparam logic [RAD_W-1:0] RADIUS_RST   = 25'd327680;
	localparam logic [FAC_W-1:0] FRICTION_RST = 17'd6554;
	localparam logic [FAC_W-1:0] RESTIT_RST   = 17'd52429;

	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_FRICTION = 2'd1;
	localparam logic [1:0] REG_RESTIT   = 2'd2;

	localparam logic [1:0] OUT_NONE    = 2'd0;
	localparam logic [1:0] OUT_PUSH    = 2'd1;
	localparam logic [1:0] OUT_IMPULSE = 2'd2;
	localparam logic [1:0] OUT_DEGEN   = 2'd3;

	typedef struct packed {
		logic signed [31:0] p1x;
		logic signed [31:0] p1y;
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] p2x;
		logic signed [31:0] p2y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
	} state_t;

	typedef struct packed {
		state_t               st;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
		logic                 contact;
	} ctx_t;

	// divide by 2^s, round to nearest with ties away from zero
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
		input int unsigned s);
		logic [63:0] mag;
		logic [63:0] q;
		mag = v[63] ? 64'(-v) : 64'(v);
		q = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -signed'(q) : signed'(q);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

### design/dpc_front.sv
// displacement, jitter, range check, squares and contact test
module dpc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  dpc_pkg::state_t             st_in,
	input  logic [15:0]                 rnd1,
	input  logic [15:0]                 rnd2,
	input  logic [dpc_pkg::RAD_W-1:0]   radius,
	output logic                        vld_out,
	output logic [dpc_pkg::SQ_W-1:0]    sq_out,
	output dpc_pkg::ctx_t               ctx_out
);
	import dpc_pkg::*;

	logic signed [32:0] dx_c, dy_c;
	logic signed [16:0] rc1_c, rc2_c;
	logic signed [31:0] jprod_c;
	logic signed [63:0] jit_full_c;

	logic               vld_s1;
	state_t             st_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [15:0] jit_s1;
	logic signed [16:0] rc1_s1, rc2_s1;

	logic signed [32:0] dxa_c, dya_c;
	logic signed [33:0] ax_c, ay_c;
	logic [25:0]        two_r_c;
	logic               inr_c;

	logic                  vld_s2;
	state_t                st_s2;
	logic signed [D_W-1:0] dx_s2, dy_s2;
	logic                  inr_s2;

	logic signed [53:0] dxsq_c, dysq_c;
	logic [51:0]        lim_c;

	logic                  vld_s3;
	state_t                st_s3;
	logic signed [D_W-1:0] dx_s3, dy_s3;
	logic                  inr_s3;
	logic [51:0]           dx2_s3, dy2_s3, lim_s3;

	logic [SQ_W-1:0] sum_c;
	logic            contact_c;

	logic            vld_s4;
	logic [SQ_W-1:0] sq_s4;
	ctx_t            ctx_s4;

	assign dx_c = 33'(st_in.p1x) - 33'(st_in.p2x);
	assign dy_c = 33'(st_in.p1y) - 33'(st_in.p2y);
	assign rc1_c = signed'({1'b0, rnd1}) - 17'sd32768;
	assign rc2_c = signed'({1'b0, rnd2}) - 17'sd32768;
	// 13107 stands for 0.2 in q0.16
	assign jprod_c = 32'(rc1_c) * 32'sd13107;
	assign jit_full_c = rshr(64'(jprod_c), 16);

	assign two_r_c = {radius, 1'b0};

	always_comb begin
		dxa_c = dx_s1;
		dya_c = dy_s1;
		if (dx_s1 == 33'sd0 && dy_s1 != 33'sd0) begin
			dxa_c = 33'(jit_s1);
		end else if (dx_s1 == 33'sd0 && dy_s1 == 33'sd0) begin
			dxa_c = 33'(rc1_s1);
			dya_c = 33'(rc2_s1);
		end
	end

	assign ax_c = dxa_c[32] ? -34'(dxa_c) : 34'(dxa_c);
	assign ay_c = dya_c[32] ? -34'(dya_c) : 34'(dya_c);
	assign inr_c = (ax_c < signed'(34'(two_r_c))) && (ay_c < signed'(34'(two_r_c)));

	assign dxsq_c = dx_s2 * dx_s2;
	assign dysq_c = dy_s2 * dy_s2;
	assign lim_c = two_r_c * two_r_c;

	assign sum_c = 53'(dx2_s3) + 53'(dy2_s3);
	assign contact_c = inr_s3 && (sum_c < 53'(lim_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_in;
		dx_s1  <= dx_c;
		dy_s1  <= dy_c;
		jit_s1 <= jit_full_c[15:0];
		rc1_s1 <= rc1_c;
		rc2_s1 <= rc2_c;

		st_s2  <= st_s1;
		dx_s2  <= dxa_c[D_W-1:0];
		dy_s2  <= dya_c[D_W-1:0];
		inr_s2 <= inr_c;

		st_s3  <= st_s2;
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		inr_s3 <= inr_s2;
		dx2_s3 <= dxsq_c[51:0];
		dy2_s3 <= dysq_c[51:0];
		lim_s3 <= lim_c;

		sq_s4  <= contact_c ? sum_c : '0;
		ctx_s4 <= '{st: st_s3, dx: dx_s3, dy: dy_s3, contact: contact_c};
	end

	assign vld_out = vld_s4;
	assign sq_out  = sq_s4;
	assign ctx_out = ctx_s4;

endmodule

### design/dpc_sqrt.sv
// pipelined integer square root, one root bit per stage, rounded to nearest
module dpc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  logic [dpc_pkg::SQ_W-1:0]    sq_in,
	input  dpc_pkg::ctx_t               ctx_in,
	output logic                        vld_out,
	output logic [dpc_pkg::DIST_W-1:0]  dist_out,
	output dpc_pkg::ctx_t               ctx_out
);
	import dpc_pkg::*;

	localparam int NSTG = DIST_W;

	logic [53:0] rem_s  [0:NSTG];
	logic [53:0] root_s [0:NSTG];
	logic        vld_s  [0:NSTG];
	ctx_t        ctx_s  [0:NSTG];

	logic              vld_sr;
	logic [DIST_W-1:0] dist_sr;
	ctx_t              ctx_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= 54'(sq_in);
		root_s[0] <= '0;
		ctx_s[0]  <= ctx_in;
	end

	for (genvar j = 0; j < NSTG; j++) begin : g_stage
		localparam logic [53:0] BIT = 54'd1 << (2 * (NSTG - 1 - j));
		logic [53:0] trial;

		assign trial = root_s[j] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[j] >= trial) begin
				rem_s[j+1]  <= rem_s[j] - trial;
				root_s[j+1] <= (root_s[j] >> 1) + BIT;
			end else begin
				rem_s[j+1]  <= rem_s[j];
				root_s[j+1] <= root_s[j] >> 1;
			end
			ctx_s[j+1] <= ctx_s[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else begin
			vld_sr <= vld_s[NSTG];
		end
	end

	// remainder above the root means the true root lies past the half step
	always_ff @(posedge clk) begin
		dist_sr <= (rem_s[NSTG] > root_s[NSTG]) ? DIST_W'(root_s[NSTG] + 54'd1)
			: root_s[NSTG][DIST_W-1:0];
		ctx_sr  <= ctx_s[NSTG];
	end

	assign vld_out  = vld_sr;
	assign dist_out = dist_sr;
	assign ctx_out  = ctx_sr;

endmodule

### design/dpc_div.sv
// two-lane pipelined restoring divider for the unit normal, one quotient bit per stage
module dpc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  logic [dpc_pkg::DIST_W-1:0]    dist_in,
	input  dpc_pkg::ctx_t                 ctx_in,
	output logic                          vld_out,
	output logic signed [dpc_pkg::N_W-1:0] nx_out,
	output logic signed [dpc_pkg::N_W-1:0] ny_out,
	output logic [dpc_pkg::DIST_W-1:0]    dist_out,
	output dpc_pkg::ctx_t                 ctx_out
);
	import dpc_pkg::*;

	localparam int QB  = N_W - 1;
	localparam int NUM_W = 44;

	logic [D_W-2:0]   magx_c, magy_c;

	logic [NUM_W-1:0]  rx_s   [0:QB];
	logic [NUM_W-1:0]  ry_s   [0:QB];
	logic [QB-1:0]     qx_s   [0:QB];
	logic [QB-1:0]     qy_s   [0:QB];
	logic              vld_s  [0:QB];
	logic [DIST_W-1:0] dist_s [0:QB];
	ctx_t              ctx_s  [0:QB];

	logic                  vld_sf;
	logic signed [N_W-1:0] nx_sf, ny_sf;
	logic [DIST_W-1:0]     dist_sf;
	ctx_t                  ctx_sf;

	assign magx_c = ctx_in.dx[D_W-1] ? (D_W-1)'(-ctx_in.dx) : ctx_in.dx[D_W-2:0];
	assign magy_c = ctx_in.dy[D_W-1] ? (D_W-1)'(-ctx_in.dy) : ctx_in.dy[D_W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	// half the divisor is added up front for round to nearest
	always_ff @(posedge clk) begin
		rx_s[0]   <= NUM_W'({magx_c, 16'd0}) + NUM_W'(dist_in >> 1);
		ry_s[0]   <= NUM_W'({magy_c, 16'd0}) + NUM_W'(dist_in >> 1);
		qx_s[0]   <= '0;
		qy_s[0]   <= '0;
		dist_s[0] <= dist_in;
		ctx_s[0]  <= ctx_in;
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int P = QB - 1 - i;
		localparam logic [QB-1:0] QBIT = QB'(1) << P;
		logic [NUM_W+1:0] sub;

		assign sub = (NUM_W+2)'(dist_s[i]) << P;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if ((NUM_W+2)'(rx_s[i]) >= sub) begin
				rx_s[i+1] <= NUM_W'((NUM_W+2)'(rx_s[i]) - sub);
				qx_s[i+1] <= qx_s[i] | QBIT;
			end else begin
				rx_s[i+1] <= rx_s[i];
				qx_s[i+1] <= qx_s[i];
			end
			if ((NUM_W+2)'(ry_s[i]) >= sub) begin
				ry_s[i+1] <= NUM_W'((NUM_W+2)'(ry_s[i]) - sub);
				qy_s[i+1] <= qy_s[i] | QBIT;
			end else begin
				ry_s[i+1] <= ry_s[i];
				qy_s[i+1] <= qy_s[i];
			end
			dist_s[i+1] <= dist_s[i];
			ctx_s[i+1]  <= ctx_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else begin
			vld_sf <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		nx_sf   <= ctx_s[QB].dx[D_W-1] ? -signed'({1'b0, qx_s[QB]}) : signed'({1'b0, qx_s[QB]});
		ny_sf   <= ctx_s[QB].dy[D_W-1] ? -signed'({1'b0, qy_s[QB]}) : signed'({1'b0, qy_s[QB]});
		dist_sf <= dist_s[QB];
		ctx_sf  <= ctx_s[QB];
	end

	assign vld_out  = vld_sf;
	assign nx_out   = nx_sf;
	assign ny_out   = ny_sf;
	assign dist_out = dist_sf;
	assign ctx_out  = ctx_sf;

endmodule

### design/dpc_resp.sv
// push, friction and restitution impulse, saturation and result select
module dpc_resp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vld_in,
	input  logic signed [dpc_pkg::N_W-1:0] nx_in,
	input  logic signed [dpc_pkg::N_W-1:0] ny_in,
	input  logic [dpc_pkg::DIST_W-1:0]     dist_in,
	input  dpc_pkg::ctx_t                  ctx_in,
	input  logic [dpc_pkg::RAD_W-1:0]      radius,
	input  logic [dpc_pkg::FAC_W-1:0]      friction,
	input  logic [dpc_pkg::FAC_W-1:0]      restit,
	output logic                           vld_out,
	output dpc_pkg::state_t                res_out,
	output logic [1:0]                     outcome_out
);
	import dpc_pkg::*;

	// r1
	logic                  vld_r1;
	state_t                st_r1;
	logic                  cont_r1, degen_r1;
	logic signed [N_W-1:0] nx_r1, ny_r1;
	logic signed [27:0]    gap_r1;
	logic signed [32:0]    rvx_r1, rvy_r1;
	// r2
	logic                  vld_r2;
	state_t                st_r2;
	logic                  cont_r2, degen_r2;
	logic signed [N_W-1:0] nx_r2, ny_r2;
	logic signed [46:0]    ppx_r2, ppy_r2;
	logic signed [51:0]    a_r2, b_r2, c_r2, d_r2;
	// r3
	logic signed [63:0]    px_c, py_c, nc_c, tc_c;
	logic                  vld_r3;
	state_t                st_r3;
	logic                  cont_r3, degen_r3;
	logic signed [N_W-1:0] nx_r3, ny_r3;
	logic signed [29:0]    px_r3, py_r3;
	logic signed [35:0]    nc_r3, tc_r3;
	// r4
	logic signed [53:0]    pf_c, pe_c;
	logic [1:0]            kind_c;
	state_t                np_c;
	logic                  vld_r4;
	state_t                st_r4, np_r4;
	logic [1:0]            kind_r4;
	logic signed [N_W-1:0] nx_r4, ny_r4;
	logic signed [53:0]    pf_r4, pe_r4;
	// r5
	logic signed [63:0]    ft_c, en_c;
	logic                  vld_r5;
	state_t                st_r5, np_r5;
	logic [1:0]            kind_r5;
	logic signed [N_W-1:0] nx_r5, ny_r5;
	logic signed [37:0]    ft_r5, en_r5;
	// r6
	logic                  vld_r6;
	state_t                st_r6, np_r6;
	logic [1:0]            kind_r6;
	logic signed [57:0]    q1_r6, q2_r6, q3_r6, q4_r6;
	// r7
	logic signed [63:0]    ix_c, iy_c;
	logic                  vld_r7;
	state_t                st_r7, np_r7;
	logic [1:0]            kind_r7;
	logic signed [39:0]    ix_r7, iy_r7;
	// r8
	state_t                res_c;
	logic                  vld_r8;
	state_t                res_r8;
	logic [1:0]            kind_r8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r1 <= 1'b0;
			vld_r2 <= 1'b0;
			vld_r3 <= 1'b0;
			vld_r4 <= 1'b0;
			vld_r5 <= 1'b0;
			vld_r6 <= 1'b0;
			vld_r7 <= 1'b0;
			vld_r8 <= 1'b0;
		end else begin
			vld_r1 <= vld_in;
			vld_r2 <= vld_r1;
			vld_r3 <= vld_r2;
			vld_r4 <= vld_r3;
			vld_r5 <= vld_r4;
			vld_r6 <= vld_r5;
			vld_r7 <= vld_r6;
			vld_r8 <= vld_r7;
		end
	end

	assign px_c = rshr(64'(ppx_r2), 17);
	assign py_c = rshr(64'(ppy_r2), 17);
	assign nc_c = rshr(64'(a_r2) + 64'(b_r2), 16);
	// tangent is (ny, -nx)
	assign tc_c = rshr(64'(c_r2) - 64'(d_r2), 16);

	assign pf_c = tc_r3 * signed'({1'b0, friction});
	assign pe_c = nc_r3 * signed'({1'b0, restit});

	always_comb begin
		priority if (!cont_r3) begin
			kind_c = OUT_NONE;
		end else if (degen_r3) begin
			kind_c = OUT_DEGEN;
		end else if (nc_r3 > 36'sd0) begin
			kind_c = OUT_PUSH;
		end else begin
			kind_c = OUT_IMPULSE;
		end
	end

	always_comb begin
		np_c     = st_r3;
		np_c.p1x = sat32(48'(st_r3.p1x) + 48'(px_r3));
		np_c.p1y = sat32(48'(st_r3.p1y) + 48'(py_r3));
		np_c.p2x = sat32(48'(st_r3.p2x) - 48'(px_r3));
		np_c.p2y = sat32(48'(st_r3.p2y) - 48'(py_r3));
	end

	assign ft_c = rshr(64'(pf_r4), 17);
	assign en_c = rshr(64'(pe_r4), 16);

	assign ix_c = rshr(64'(q1_r6), 16) + rshr(64'(q3_r6), 16);
	assign iy_c = rshr(64'(q4_r6), 16) - rshr(64'(q2_r6), 16);

	always_comb begin
		res_c = st_r7;
		if (kind_r7 == OUT_PUSH || kind_r7 == OUT_IMPULSE) begin
			res_c.p1x = np_r7.p1x;
			res_c.p1y = np_r7.p1y;
			res_c.p2x = np_r7.p2x;
			res_c.p2y = np_r7.p2y;
		end
		if (kind_r7 == OUT_IMPULSE) begin
			res_c.v1x = sat32(48'(st_r7.v1x) - 48'(ix_r7));
			res_c.v1y = sat32(48'(st_r7.v1y) - 48'(iy_r7));
			res_c.v2x = sat32(48'(st_r7.v2x) + 48'(ix_r7));
			res_c.v2y = sat32(48'(st_r7.v2y) + 48'(iy_r7));
		end
	end

	always_ff @(posedge clk) begin
		st_r1    <= ctx_in.st;
		cont_r1  <= ctx_in.contact;
		degen_r1 <= ctx_in.contact && (dist_in == '0);
		nx_r1    <= nx_in;
		ny_r1    <= ny_in;
		gap_r1   <= signed'({2'b00, radius, 1'b0}) - signed'({1'b0, dist_in});
		rvx_r1   <= 33'(ctx_in.st.v1x) - 33'(ctx_in.st.v2x);
		rvy_r1   <= 33'(ctx_in.st.v1y) - 33'(ctx_in.st.v2y);

		st_r2    <= st_r1;
		cont_r2  <= cont_r1;
		degen_r2 <= degen_r1;
		nx_r2    <= nx_r1;
		ny_r2    <= ny_r1;
		ppx_r2   <= nx_r1 * gap_r1;
		ppy_r2   <= ny_r1 * gap_r1;
		a_r2     <= rvx_r1 * nx_r1;
		b_r2     <= rvy_r1 * ny_r1;
		c_r2     <= rvx_r1 * ny_r1;
		d_r2     <= rvy_r1 * nx_r1;

		st_r3    <= st_r2;
		cont_r3  <= cont_r2;
		degen_r3 <= degen_r2;
		nx_r3    <= nx_r2;
		ny_r3    <= ny_r2;
		px_r3    <= px_c[29:0];
		py_r3    <= py_c[29:0];
		nc_r3    <= nc_c[35:0];
		tc_r3    <= tc_c[35:0];

		st_r4     <= st_r3;
		np_r4     <= np_c;
		kind_r4   <= kind_c;
		nx_r4     <= nx_r3;
		ny_r4     <= ny_r3;
		pf_r4     <= pf_c;
		pe_r4     <= pe_c;

		st_r5   <= st_r4;
		np_r5   <= np_r4;
		kind_r5 <= kind_r4;
		nx_r5   <= nx_r4;
		ny_r5   <= ny_r4;
		ft_r5   <= ft_c[37:0];
		en_r5   <= en_c[37:0];

		st_r6   <= st_r5;
		np_r6   <= np_r5;
		kind_r6 <= kind_r5;
		q1_r6   <= ny_r5 * ft_r5;
		q2_r6   <= nx_r5 * ft_r5;
		q3_r6   <= nx_r5 * en_r5;
		q4_r6   <= ny_r5 * en_r5;

		st_r7   <= st_r6;
		np_r7   <= np_r6;
		kind_r7 <= kind_r6;
		ix_r7   <= ix_c[39:0];
		iy_r7   <= iy_c[39:0];

		res_r8  <= res_c;
		kind_r8 <= kind_r7;
	end

	assign vld_out     = vld_r8;
	assign res_out     = res_r8;
	assign outcome_out = kind_r8;

endmodule

### design/disc_pair_collision_response_unit.sv
// top level of the disc pair collision response unit
// Fully pipelined: one disc pair is taken in every clock cycle (start with busy, which
// stays low) and its result appears on the result ports for one cycle, marked by done;
// the receiver cannot stall it. Inside are the bit-per-stage square root (27 stages
// plus rounding) and the bit-per-stage normal divider (18 stages plus setup and sign).
// Registers are written through cfg_we/cfg_idx/cfg_wdata, by the user and only while
// no item is in flight, which the block does not enforce; unknown indexes are ignored.
module disc_pair_collision_response_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic                      done,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [dpc_pkg::RAD_W-1:0] cfg_wdata,
	input  logic signed [31:0]        first_pos_x,
	input  logic signed [31:0]        first_pos_y,
	input  logic signed [31:0]        first_vel_x,
	input  logic signed [31:0]        first_vel_y,
	input  logic signed [31:0]        second_pos_x,
	input  logic signed [31:0]        second_pos_y,
	input  logic signed [31:0]        second_vel_x,
	input  logic signed [31:0]        second_vel_y,
	input  logic [15:0]               random_first,
	input  logic [15:0]               random_second,
	output logic signed [31:0]        new_first_pos_x,
	output logic signed [31:0]        new_first_pos_y,
	output logic signed [31:0]        new_first_vel_x,
	output logic signed [31:0]        new_first_vel_y,
	output logic signed [31:0]        new_second_pos_x,
	output logic signed [31:0]        new_second_pos_y,
	output logic signed [31:0]        new_second_vel_x,
	output logic signed [31:0]        new_second_vel_y,
	output logic [1:0]                outcome
);
	import dpc_pkg::*;

	logic [RAD_W-1:0] radius_q;
	logic [FAC_W-1:0] friction_q;
	logic [FAC_W-1:0] restit_q;

	state_t st_in;
	state_t res;

	logic              f_vld;
	logic [SQ_W-1:0]   f_sq;
	ctx_t              f_ctx;
	logic              s_vld;
	logic [DIST_W-1:0] s_dist;
	ctx_t              s_ctx;
	logic              d_vld;
	logic signed [N_W-1:0] d_nx, d_ny;
	logic [DIST_W-1:0] d_dist;
	ctx_t              d_ctx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RADIUS_RST;
			friction_q <= FRICTION_RST;
			restit_q   <= RESTIT_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_RADIUS) begin
				radius_q <= cfg_wdata;
			end else if (cfg_idx == REG_FRICTION) begin
				friction_q <= cfg_wdata[FAC_W-1:0];
			end else if (cfg_idx == REG_RESTIT) begin
				restit_q <= cfg_wdata[FAC_W-1:0];
			end
		end
	end

	assign busy = 1'b0;

	assign st_in.p1x = first_pos_x;
	assign st_in.p1y = first_pos_y;
	assign st_in.v1x = first_vel_x;
	assign st_in.v1y = first_vel_y;
	assign st_in.p2x = second_pos_x;
	assign st_in.p2y = second_pos_y;
	assign st_in.v2x = second_vel_x;
	assign st_in.v2y = second_vel_y;

	dpc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start && !busy),
		.st_in   (st_in),
		.rnd1    (random_first),
		.rnd2    (random_second),
		.radius  (radius_q),
		.vld_out (f_vld),
		.sq_out  (f_sq),
		.ctx_out (f_ctx)
	);

	dpc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (f_vld),
		.sq_in    (f_sq),
		.ctx_in   (f_ctx),
		.vld_out  (s_vld),
		.dist_out (s_dist),
		.ctx_out  (s_ctx)
	);

	dpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (s_vld),
		.dist_in  (s_dist),
		.ctx_in   (s_ctx),
		.vld_out  (d_vld),
		.nx_out   (d_nx),
		.ny_out   (d_ny),
		.dist_out (d_dist),
		.ctx_out  (d_ctx)
	);

	dpc_resp u_resp (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_in      (d_vld),
		.nx_in       (d_nx),
		.ny_in       (d_ny),
		.dist_in     (d_dist),
		.ctx_in      (d_ctx),
		.radius      (radius_q),
		.friction    (friction_q),
		.restit      (restit_q),
		.vld_out     (done),
		.res_out     (res),
		.outcome_out (outcome)
	);

	assign new_first_pos_x  = res.p1x;
	assign new_first_pos_y  = res.p1y;
	assign new_first_vel_x  = res.v1x;
	assign new_first_vel_y  = res.v1y;
	assign new_second_pos_x = res.p2x;
	assign new_second_pos_y = res.p2y;
	assign new_second_vel_x = res.v2x;
	assign new_second_vel_y = res.v2y;

endmodule
